// ===== rtl/bgd_pkg.sv =====
// Shared types and constants of the button gesture detector.
package bgd_pkg;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_WINDOW  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_THRESHOLD = 1'b1;

  localparam logic [CFG_DATA_W-1:0] DOUBLE_WINDOW_RESET  = 16'd300;
  localparam logic [CFG_DATA_W-1:0] HOLD_THRESHOLD_RESET = 16'd800;

  // Fixed field widths
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned PHASE_W = 3;

  // Gesture phases; codes above PH_SECOND are never produced
  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE   = 3'd0,
    PH_DOWN   = 3'd1,
    PH_HELD   = 3'd2,
    PH_WAIT   = 3'd3,
    PH_SECOND = 3'd4
  } phase_t;

  // Configuration registers as seen by the state machine
  typedef struct packed {
    logic [CFG_DATA_W-1:0] double_window;
    logic [CFG_DATA_W-1:0] hold_threshold;
  } cfg_t;

  // One input sample
  typedef struct packed {
    logic               button_level;
    logic [STAMP_W-1:0] now_ms;
    logic               clear_single;
    logic               clear_double;
    logic               clear_hold;
  } in_item_t;

  // One result
  typedef struct packed {
    logic               single_seen;
    logic               double_seen;
    logic               hold_seen;
    logic [PHASE_W-1:0] gesture_phase;
  } out_item_t;

endpackage

// ===== rtl/bgd_in_if.sv =====
// Sample channel: valid/ready handshake with the button sample payload.
interface bgd_in_if;
  logic        valid;
  logic        ready;
  logic        button_level;
  logic [31:0] now_ms;
  logic        clear_single;
  logic        clear_double;
  logic        clear_hold;

  modport source (
    output valid, button_level, now_ms, clear_single, clear_double, clear_hold,
    input  ready
  );

  modport sink (
    input  valid, button_level, now_ms, clear_single, clear_double, clear_hold,
    output ready
  );
endinterface

// ===== rtl/bgd_out_if.sv =====
// Result channel: valid/ready handshake with the gesture flags and phase.
interface bgd_out_if;
  logic       valid;
  logic       ready;
  logic       single_seen;
  logic       double_seen;
  logic       hold_seen;
  logic [2:0] gesture_phase;

  modport source (
    output valid, single_seen, double_seen, hold_seen, gesture_phase,
    input  ready
  );

  modport sink (
    input  valid, single_seen, double_seen, hold_seen, gesture_phase,
    output ready
  );
endinterface

// ===== rtl/bgd_cfg.sv =====
// Configuration registers: double-press window and hold threshold.
module bgd_cfg
  import bgd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   we,
  input  logic [CFG_INDEX_W-1:0] index,
  input  logic [CFG_DATA_W-1:0]  data,
  output cfg_t                   cfg
);

  cfg_t regs;

  // Register file, written one register per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.double_window  <= DOUBLE_WINDOW_RESET;
      regs.hold_threshold <= HOLD_THRESHOLD_RESET;
    end else if (we) begin
      case (index)
        REG_DOUBLE_WINDOW:  regs.double_window  <= data;
        REG_HOLD_THRESHOLD: regs.hold_threshold <= data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== rtl/bgd_fsm.sv =====
// Gesture state machine: edge detection, phase, press start time and sticky flags.
module bgd_fsm
  import bgd_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);

  phase_t                phase;
  phase_t                phase_next;
  logic [TIME_WIDTH-1:0] press_start;
  logic [TIME_WIDTH-1:0] press_start_next;
  logic                  previous_level;
  logic                  single_flag;
  logic                  double_flag;
  logic                  hold_flag;

  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  falling;
  logic                  rising;
  logic                  in_window;
  logic                  hold_reached;
  logic                  set_single;
  logic                  set_double;
  logic                  set_hold;
  logic                  single_now;
  logic                  double_now;
  logic                  hold_now;

  // Timestamp reduced to the time width; differences wrap
  assign now_t        = TIME_WIDTH'(item.now_ms);
  assign elapsed      = now_t - press_start;
  assign falling      = !item.button_level && previous_level;
  assign rising       = item.button_level && !previous_level;
  assign in_window    = elapsed <= TIME_WIDTH'(cfg.double_window);
  assign hold_reached = elapsed >= TIME_WIDTH'(cfg.hold_threshold);

  // Next phase and flag set conditions
  always_comb begin
    phase_next       = phase;
    press_start_next = press_start;
    set_single       = 1'b0;
    set_double       = 1'b0;
    set_hold         = 1'b0;
    case (phase)
      PH_DOWN: begin
        if (!item.button_level && hold_reached) begin
          set_hold   = 1'b1;
          phase_next = PH_HELD;
        end
        if (rising) phase_next = PH_WAIT;
      end
      PH_HELD, PH_SECOND: begin
        if (rising) phase_next = PH_IDLE;
      end
      PH_WAIT: begin
        if (falling) begin
          if (in_window) begin
            set_double = 1'b1;
            phase_next = PH_SECOND;
          end else begin
            // late second press counts as a new first press
            set_single       = 1'b1;
            press_start_next = now_t;
            phase_next       = PH_DOWN;
          end
        end else if (!in_window) begin
          set_single = 1'b1;
          phase_next = PH_IDLE;
        end
      end
      default: begin
        if (falling) begin
          press_start_next = now_t;
          phase_next       = PH_DOWN;
        end else begin
          phase_next = PH_IDLE;
        end
      end
    endcase
  end

  // Flags as reported; the clear bits act only after the report
  assign single_now = single_flag | set_single;
  assign double_now = double_flag | set_double;
  assign hold_now   = hold_flag | set_hold;

  assign res.single_seen   = single_now;
  assign res.double_seen   = double_now;
  assign res.hold_seen     = hold_now;
  assign res.gesture_phase = phase_next;

  // Phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  // Level, start time and flag registers
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= 1'b1;
      press_start    <= '0;
      single_flag    <= 1'b0;
      double_flag    <= 1'b0;
      hold_flag      <= 1'b0;
    end else if (step) begin
      previous_level <= item.button_level;
      press_start    <= press_start_next;
      single_flag    <= single_now & ~item.clear_single;
      double_flag    <= double_now & ~item.clear_double;
      hold_flag      <= hold_now & ~item.clear_hold;
    end
  end

  // Entering the held phase always reports the hold flag
  a_hold_entry: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_DOWN && phase_next == PH_HELD |-> res.hold_seen)
    else $error("held phase entered without hold flag");

  // Entering the second-press phase always reports the double flag
  a_double_entry: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_WAIT && phase_next == PH_SECOND |-> res.double_seen)
    else $error("second press entered without double flag");

  // State moves only when a sample is processed
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(press_start) && $stable(previous_level))
    else $error("gesture state changed without a sample");

endmodule

// ===== rtl/button_gesture_detector.sv =====
// Button gesture detector: top level with sample register, state machine and result register.
//
// Usage:
//   Samples arrive on in_ch (valid/ready); each carries the button level
//   (1 released, 0 pressed), a wrapping millisecond timestamp and three clear
//   bits. Every sample gives exactly one result on out_ch: the single, double
//   and hold flags after the update and the gesture phase (0 idle, 1 down,
//   2 held, 3 waiting for second press, 4 second press down). Clear bits
//   drop a flag after the result of that sample has reported it.
//   Each sample is held in the sample register and its result then in the
//   result register, which drives out_ch.
//   Throughput: one sample per cycle while out_ch does not stall; the sample
//   register and the result register each take a new transfer whenever the
//   stage downstream moves. When out_ch stalls, the result register holds,
//   one further sample waits in the sample register and in_ch.ready then drops.
//   cfg_we writes the register at cfg_index (0 double window, 1 hold
//   threshold) with cfg_data; write only while no sample is in flight.
//   Reset (rst, synchronous) empties both registers, restores the window to
//   300 ms and the threshold to 800 ms, phase idle, level released, flags
//   clear.
module button_gesture_detector
  import bgd_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  bgd_in_if.sink                 in_ch,
  bgd_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t      cfg;
  in_item_t  in_item;
  logic      in_vld;
  out_item_t res;
  out_item_t out_item;
  logic      out_vld;
  logic      advance;

  bgd_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // Sample moves into the result register when that register is free or drains
  assign advance     = in_vld && (!out_vld || out_ch.ready);
  assign in_ch.ready = !in_vld || advance;

  // Sample register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item.button_level <= in_ch.button_level;
      in_item.now_ms       <= in_ch.now_ms;
      in_item.clear_single <= in_ch.clear_single;
      in_item.clear_double <= in_ch.clear_double;
      in_item.clear_hold   <= in_ch.clear_hold;
    end
  end

  bgd_fsm #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_fsm (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= res;
    end
  end

  assign out_ch.valid         = out_vld;
  assign out_ch.single_seen   = out_item.single_seen;
  assign out_ch.double_seen   = out_item.double_seen;
  assign out_ch.hold_seen     = out_item.hold_seen;
  assign out_ch.gesture_phase = out_item.gesture_phase;

  // A processed sample always lands in the result register
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_vld)
    else $error("processed sample produced no result");

  // A waiting sample is never dropped while the output stalls
  a_sample_kept: assert property (@(posedge clk) disable iff (rst)
    in_vld && !advance |=> in_vld)
    else $error("waiting sample lost");

  // A stalled result is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_vld && !out_ch.ready |-> !advance)
    else $error("stalled result overwritten");

endmodule

// ===== tb/sv/button_gesture_detector_tb.sv =====
// Self-checking testbench for the button gesture detector: stimulus, predictor and result check.
`timescale 1ns / 1ps

module button_gesture_detector_tb;
  import bgd_pkg::*;

  // Clear bit masks, ordered {single, double, hold}
  localparam logic [2:0] CLR_NONE   = 3'b000;
  localparam logic [2:0] CLR_SINGLE = 3'b100;
  localparam logic [2:0] CLR_DOUBLE = 3'b010;
  localparam logic [2:0] CLR_HOLD   = 3'b001;
  localparam logic [2:0] CLR_ALL    = 3'b111;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  bgd_in_if  in_ch ();
  bgd_out_if out_ch ();

  button_gesture_detector DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Samples waiting to be driven, and flag/phase results still owed by the block
  in_item_t  pending[$];
  out_item_t flags_due[$];

  // Predictor state and its copy of the registers
  logic                  m_level  = 1'b1;
  phase_t                m_phase  = PH_IDLE;
  logic [STAMP_W-1:0]    m_start  = '0;
  logic                  m_single = 1'b0;
  logic                  m_double = 1'b0;
  logic                  m_hold_f = 1'b0;
  logic [CFG_DATA_W-1:0] m_window = DOUBLE_WINDOW_RESET;
  logic [CFG_DATA_W-1:0] m_hold   = HOLD_THRESHOLD_RESET;

  // Stimulus bookkeeping and run statistics
  logic [STAMP_W-1:0] stamp = '0;
  int planned         = 0;
  int samples_sent    = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int settings_used   = 1;
  int drains          = 0;
  int singles_set     = 0;
  int doubles_set     = 0;
  int holds_set       = 0;

  // Sender pacing
  in_item_t cur_sample;
  int       burst_left = 1;
  int       gap_left   = 0;
  logic     drain_wait = 1'b0;

  // Receiver stall pattern
  int ready_style = 0;
  int style_left  = 50;
  int stall_left  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #4_000_000;
    $display("timeout: %0d results still owed, %0d samples not sent",
             flags_due.size(), pending.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Gesture state machine: one sample in, flags and phase after the update out
  function automatic out_item_t gesture_step(input in_item_t s);
    out_item_t          r;
    logic               falling;
    logic               rising;
    logic [STAMP_W-1:0] since;
    falling = !s.button_level && m_level;
    rising  = s.button_level && !m_level;
    since   = s.now_ms - m_start;
    case (m_phase)
      PH_DOWN: begin
        if (!s.button_level && since >= m_hold) begin
          m_hold_f = 1'b1;
          m_phase  = PH_HELD;
          holds_set++;
        end
        if (rising) m_phase = PH_WAIT;
      end
      PH_HELD, PH_SECOND: begin
        if (rising) m_phase = PH_IDLE;
      end
      PH_WAIT: begin
        if (falling) begin
          if (since <= m_window) begin
            m_double = 1'b1;
            m_phase  = PH_SECOND;
            doubles_set++;
          end else begin
            // late second press: counts as a single, starts a new first press
            m_single = 1'b1;
            m_start  = s.now_ms;
            m_phase  = PH_DOWN;
            singles_set++;
          end
        end else if (since > m_window) begin
          m_single = 1'b1;
          m_phase  = PH_IDLE;
          singles_set++;
        end
      end
      default: begin
        if (falling) begin
          m_start = s.now_ms;
          m_phase = PH_DOWN;
        end else begin
          m_phase = PH_IDLE;
        end
      end
    endcase
    m_level = s.button_level;

    r.single_seen   = m_single;
    r.double_seen   = m_double;
    r.hold_seen     = m_hold_f;
    r.gesture_phase = m_phase;

    // clears act after the flags have been reported
    if (s.clear_single) m_single = 1'b0;
    if (s.clear_double) m_double = 1'b0;
    if (s.clear_hold)   m_hold_f = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [2:0] got, input logic [2:0] want);
    mismatches++;
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  // Sample queue helpers
  task automatic push_at(input logic lvl, input logic [STAMP_W-1:0] at, input logic [2:0] clr);
    in_item_t s;
    s.button_level = lvl;
    s.now_ms       = at;
    s.clear_single = clr[2];
    s.clear_double = clr[1];
    s.clear_hold   = clr[0];
    stamp = at;
    pending.push_back(s);
    planned++;
  endtask

  task automatic push_sample(input logic lvl, input logic [STAMP_W-1:0] dt, input logic [2:0] clr);
    push_at(lvl, stamp + dt, clr);
  endtask

  function automatic logic [2:0] rand_clears();
    return {$urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0};
  endfunction

  // A time step clustered around a threshold, so both sides of each compare are hit
  function automatic logic [STAMP_W-1:0] near(input logic [STAMP_W-1:0] span);
    case ($urandom_range(0, 6))
      0:       return span;
      1:       return span + 1;
      2:       return (span == 0) ? span : span - 1;
      3:       return $urandom_range(0, span);
      4:       return span + $urandom_range(1, 50);
      5:       return $urandom;
      default: return $urandom_range(0, 2 * span + 2);
    endcase
  endfunction

  // One random gesture, mostly well formed
  task automatic add_gesture();
    logic [STAMP_W-1:0] w;
    logic [STAMP_W-1:0] h;
    logic [STAMP_W-1:0] d1;
    logic [STAMP_W-1:0] d2;
    int                 n;
    w = m_window;
    h = m_hold;
    case ($urandom_range(0, 11))
      0, 1, 2: begin
        // single press, released before or after the hold time
        push_sample(1'b1, near(w), rand_clears());
        push_sample(1'b0, $urandom_range(0, 50), rand_clears());
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) push_sample(1'b0, near(h) / 2, rand_clears());
        push_sample(1'b1, $urandom_range(0, h), rand_clears());
        push_sample(1'b1, near(w), rand_clears());
        push_sample(1'b1, near(w), rand_clears());
      end
      3, 4, 5: begin
        // double press, second press placed around the window edge
        push_sample(1'b1, near(w), rand_clears());
        push_sample(1'b0, $urandom_range(0, 50), rand_clears());
        d2 = near(w);
        d1 = (d2 == 0) ? d2 : $urandom_range(0, d2);
        push_sample(1'b1, d1, rand_clears());
        push_sample(1'b0, d2 - d1, rand_clears());
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) push_sample(1'b0, near(h), rand_clears());
        push_sample(1'b1, $urandom_range(0, 100), rand_clears());
      end
      6, 7, 8: begin
        // long press around the hold threshold
        push_sample(1'b1, near(w), rand_clears());
        push_sample(1'b0, $urandom_range(0, 50), rand_clears());
        push_sample(1'b0, near(h), rand_clears());
        if ($urandom_range(0, 1)) push_sample(1'b0, $urandom_range(0, 20), rand_clears());
        push_sample(1'b1, $urandom_range(0, 20), rand_clears());
        push_sample(1'b1, near(w), rand_clears());
      end
      9: begin
        // timestamps just short of wrapping
        push_at(1'b1, 32'hFFFF_FFFF - $urandom_range(0, 2000), rand_clears());
      end
      default: begin
        // noise: random levels, steps and absolute stamps
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) == 0)
            push_at(1'($urandom_range(0, 1)), $urandom, rand_clears());
          else
            push_sample(1'($urandom_range(0, 1)), $urandom_range(0, 3 * w + 3), rand_clears());
        end
      end
    endcase
  endtask

  task automatic add_random(input int count);
    int target;
    target = planned + count;
    while (planned < target) add_gesture();
  endtask

  // Waits until the block has nothing in flight
  task automatic wait_idle();
    do @(posedge clk);
    while (pending.size() != 0 || in_ch.valid || flags_due.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_DOUBLE_WINDOW) m_window = val;
    else m_hold = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic new_setting(input logic [CFG_DATA_W-1:0] win, input logic [CFG_DATA_W-1:0] thr);
    wait_idle();
    write_reg(REG_DOUBLE_WINDOW, win);
    write_reg(REG_HOLD_THRESHOLD, thr);
    settings_used++;
  endtask

  // Sample driver: bursts with random gaps, plus occasional full drains
  always @(posedge clk) begin : sample_driver
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        flags_due.push_back(gesture_step(cur_sample));
        samples_sent++;
        if (samples_sent % 400 == 200) begin
          drain_wait = 1'b1;
          drains++;
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (drain_wait && flags_due.size() != 0) begin
          in_ch.valid <= 1'b0;
        end else if (gap_left != 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else begin
          drain_wait = 1'b0;
          cur_sample = pending.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.button_level <= cur_sample.button_level;
          in_ch.now_ms       <= cur_sample.now_ms;
          in_ch.clear_single <= cur_sample.clear_single;
          in_ch.clear_double <= cur_sample.clear_double;
          in_ch.clear_hold   <= cur_sample.clear_hold;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Result monitor: check each transfer against the oldest prediction, then pace ready
  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (flags_due.size() == 0) begin
          report_mismatch("result with nothing expected", out_ch.gesture_phase, 3'd0);
        end else begin
          want = flags_due.pop_front();
          if (out_ch.single_seen !== want.single_seen)
            report_mismatch("single_seen", 3'(out_ch.single_seen), 3'(want.single_seen));
          if (out_ch.double_seen !== want.double_seen)
            report_mismatch("double_seen", 3'(out_ch.double_seen), 3'(want.double_seen));
          if (out_ch.hold_seen !== want.hold_seen)
            report_mismatch("hold_seen", 3'(out_ch.hold_seen), 3'(want.hold_seen));
          if (out_ch.gesture_phase !== want.gesture_phase)
            report_mismatch("gesture_phase", out_ch.gesture_phase, want.gesture_phase);
          results_checked++;
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (ready_style)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 20);
          end
        endcase
        if (style_left == 0) begin
          ready_style = $urandom_range(0, 3);
          style_left  = $urandom_range(20, 200);
        end else begin
          style_left--;
        end
      end
    end
  end

  // Stimulus sequence and end of run
  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = REG_DOUBLE_WINDOW;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.button_level = 1'b1;
    in_ch.now_ms       = '0;
    in_ch.clear_single = 1'b0;
    in_ch.clear_double = 1'b0;
    in_ch.clear_hold   = 1'b0;
    out_ch.ready       = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: hold across the stamp wrap, exact window edge, late press, expiry
    push_at(1'b1, 32'h0000_0000, CLR_NONE);
    push_at(1'b1, 32'hFFFF_FE00, CLR_NONE);
    push_sample(1'b0, 32'h10, CLR_NONE);
    push_sample(1'b0, 799, CLR_NONE);
    push_sample(1'b0, 1, CLR_NONE);
    push_sample(1'b1, 5, CLR_HOLD);
    push_sample(1'b0, 1000, CLR_NONE);
    push_sample(1'b1, 100, CLR_NONE);
    push_sample(1'b0, 200, CLR_NONE);
    push_sample(1'b1, 10, CLR_DOUBLE);
    push_sample(1'b0, 1000, CLR_NONE);
    push_sample(1'b1, 50, CLR_NONE);
    push_sample(1'b0, 251, CLR_SINGLE);
    push_sample(1'b1, 10, CLR_NONE);
    push_sample(1'b1, 291, CLR_NONE);
    push_sample(1'b1, 5, CLR_ALL);
    push_at(1'b0, 32'hFFFF_FFFF, CLR_NONE);
    push_sample(1'b1, 1, CLR_NONE);
    push_sample(1'b1, 299, CLR_NONE);
    push_sample(1'b1, 1, CLR_ALL);
    add_random(200);

    // Zero window and zero hold time
    new_setting(16'd0, 16'd0);
    push_sample(1'b1, 20, CLR_NONE);
    push_sample(1'b0, 10, CLR_NONE);
    push_sample(1'b0, 0, CLR_NONE);
    push_sample(1'b1, 3, CLR_HOLD);
    push_sample(1'b0, 7, CLR_NONE);
    push_sample(1'b1, 0, CLR_NONE);
    push_sample(1'b0, 0, CLR_DOUBLE);
    push_sample(1'b1, 4, CLR_NONE);
    push_sample(1'b0, 9, CLR_NONE);
    push_sample(1'b1, 0, CLR_NONE);
    push_sample(1'b0, 1, CLR_ALL);
    add_random(250);

    // Largest values
    new_setting(16'hFFFF, 16'hFFFF);
    add_random(250);

    // Arbitrary values, then short times, then back to the reset values
    new_setting(16'($urandom_range(1, 65534)), 16'($urandom_range(1, 65534)));
    add_random(250);
    new_setting(16'd20, 16'd50);
    add_random(250);
    new_setting(DOUBLE_WINDOW_RESET, HOLD_THRESHOLD_RESET);
    add_random(200);

    wait_idle();
    repeat (10) @(posedge clk);

    $display("Covered %0d samples under %0d register settings, %0d results checked, %0d drains.",
             samples_sent, settings_used, results_checked, drains);
    $display("Predicted flag sets: %0d single, %0d double, %0d hold.",
             singles_set, doubles_set, holds_set);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
